// ===== src/tone_note_queue_sequencer_macros.svh =====
// Assertion macros for the tone note queue sequencer.
// Included by the top level; expects clk and rst_n in scope.
`ifndef TONE_NOTE_QUEUE_SEQUENCER_MACROS_SVH
`define TONE_NOTE_QUEUE_SEQUENCER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TNQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define TNQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tnq_pkg.sv =====
// Shared types and constants for the tone note queue sequencer.
// No dependencies.
package tnq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;

  localparam int PRESCALE_W = 3;
  localparam int COMPARE_W  = 8;
  localparam int DURATION_W = 16;
  localparam int QUEUED_W   = 4;
  localparam int NOTE_W     = PRESCALE_W + COMPARE_W + DURATION_W;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic [PRESCALE_W-1:0] prescale;
    logic [COMPARE_W-1:0]  compare;
    logic [DURATION_W-1:0] duration;
  } note_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // word taken this cycle
    logic push_wr;    // write note at write index
    logic drop;       // push refused, queue full
    logic tick_dec;   // count down time left
    logic rd_issue;   // read note at read index
    logic load_note;  // read data valid, start the note
    logic emit;       // capture result word
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic time_nz;
  } dp_status_t;

endpackage

// ===== src/tnq_if.sv =====
// Valid/ready channel interfaces for the note input and result words.
// Depends on tnq_pkg.
interface tnq_in_if import tnq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [PRESCALE_W-1:0] note_prescale;
  logic [COMPARE_W-1:0]  note_compare;
  logic [DURATION_W-1:0] note_duration;

  modport source (output valid, cmd, note_prescale, note_compare, note_duration,
                  input ready);
  modport sink   (input valid, cmd, note_prescale, note_compare, note_duration,
                  output ready);
endinterface

interface tnq_out_if import tnq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  tone_on;
  logic [PRESCALE_W-1:0] tone_prescale;
  logic [COMPARE_W-1:0]  tone_compare;
  logic [QUEUED_W-1:0]   queued_notes;
  logic                  push_dropped;

  modport source (output valid, tone_on, tone_prescale, tone_compare, queued_notes,
                  push_dropped, input ready);
  modport sink   (input valid, tone_on, tone_prescale, tone_compare, queued_notes,
                  push_dropped, output ready);
endinterface

// ===== src/tnq_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// Depends on tnq_pkg for default sizes.
module tnq_ram import tnq_pkg::*; #(
  parameter int WIDTH = NOTE_W,
  parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/tnq_datapath.sv =====
// Queue indices, note store, countdown, active tone and result register.
// Depends on tnq_pkg and tnq_ram.
module tnq_datapath import tnq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_cmd_t              cmd,
  output dp_status_t            status,
  input  logic [PRESCALE_W-1:0] note_prescale,
  input  logic [COMPARE_W-1:0]  note_compare,
  input  logic [DURATION_W-1:0] note_duration,
  output logic                  tone_on,
  output logic [PRESCALE_W-1:0] tone_prescale,
  output logic [COMPARE_W-1:0]  tone_compare,
  output logic [QUEUED_W-1:0]   queued_notes,
  output logic                  push_dropped
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam logic [IDX_W:0]   DEPTH_C = (IDX_W+1)'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_C  = IDX_W'(QUEUE_DEPTH - 1);

  logic [IDX_W-1:0]      wr_idx_r, rd_idx_r;
  logic [IDX_W-1:0]      wr_idx_nxt, rd_idx_nxt;
  logic [DURATION_W-1:0] time_left_r;
  logic [PRESCALE_W-1:0] act_pre_r;
  logic [COMPARE_W-1:0]  act_cmp_r;
  logic                  drop_r;
  logic [PRESCALE_W-1:0] out_pre_r;
  logic [COMPARE_W-1:0]  out_cmp_r;
  logic [QUEUED_W-1:0]   out_fill_r;
  logic                  out_drop_r;
  logic [IDX_W:0]        diff, fill_wide;
  logic [IDX_W-1:0]      fill;
  note_t                 wr_note, rd_note;

  assign wr_note = '{prescale: note_prescale, compare: note_compare,
                     duration: note_duration};

  tnq_ram #(.WIDTH(NOTE_W), .DEPTH(QUEUE_DEPTH)) u_store (
    .clk  (clk),
    .we   (cmd.push_wr),
    .waddr(wr_idx_r),
    .wdata(wr_note),
    .re   (cmd.rd_issue),
    .raddr(rd_idx_r),
    .rdata(rd_note)
  );

  // ring fill, works for any depth
  always_comb begin
    diff      = {1'b0, wr_idx_r} - {1'b0, rd_idx_r};
    fill_wide = (wr_idx_r >= rd_idx_r) ? diff : diff + DEPTH_C;
    fill      = fill_wide[IDX_W-1:0];
  end

  assign wr_idx_nxt = (wr_idx_r == LAST_C) ? '0 : wr_idx_r + 1'b1;
  assign rd_idx_nxt = (rd_idx_r == LAST_C) ? '0 : rd_idx_r + 1'b1;

  assign status.full    = (fill == LAST_C);
  assign status.empty   = (wr_idx_r == rd_idx_r);
  assign status.time_nz = (time_left_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      time_left_r <= '0;
      act_pre_r   <= '0;
      act_cmp_r   <= '0;
      drop_r      <= 1'b0;
    end else begin
      if (cmd.accept) begin
        drop_r <= cmd.drop;
      end
      if (cmd.push_wr) begin
        wr_idx_r <= wr_idx_nxt;
      end
      if (cmd.tick_dec) begin
        time_left_r <= time_left_r - 1'b1;
        if (time_left_r == DURATION_W'(1)) begin
          act_pre_r <= '0;
        end
      end
      if (cmd.load_note) begin
        time_left_r <= rd_note.duration;
        act_pre_r   <= rd_note.prescale;
        act_cmp_r   <= rd_note.compare;
        rd_idx_r    <= rd_idx_nxt;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pre_r  <= act_pre_r;
      out_cmp_r  <= act_cmp_r;
      out_fill_r <= QUEUED_W'(fill);
      out_drop_r <= drop_r;
    end
  end

  assign tone_on       = (out_pre_r != '0);
  assign tone_prescale = out_pre_r;
  assign tone_compare  = out_cmp_r;
  assign queued_notes  = out_fill_r;
  assign push_dropped  = out_drop_r;

endmodule

// ===== src/tnq_controller.sv =====
// Sequencing state machine: accept, optional note fetch, result hand-off.
// Depends on tnq_pkg.
module tnq_controller import tnq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_cmd,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   is_push, is_tick;

  assign in_ready = rst_n && (state_r == S_IDLE);
  assign is_push  = (in_cmd == CMD_PUSH);
  assign is_tick  = (in_cmd == CMD_TICK);

  always_comb begin
    cmd           = '0;
    cmd.accept    = in_valid && in_ready;
    cmd.push_wr   = cmd.accept && is_push && !status.full;
    cmd.drop      = cmd.accept && is_push && status.full;
    cmd.tick_dec  = cmd.accept && is_tick && status.time_nz;
    cmd.rd_issue  = cmd.accept && is_tick && !status.time_nz && !status.empty;
    cmd.load_note = (state_r == S_FETCH);
    cmd.emit      = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept) begin
          state_nxt = cmd.rd_issue ? S_FETCH : S_EMIT;
        end
      end
      S_FETCH: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (cmd.emit) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/tone_note_queue_sequencer.sv =====
// Tone note queue sequencer top level: controller, datapath, assertions.
// Depends on tnq_pkg, tnq_if, tnq_controller, tnq_datapath and the macros header.
//
//  channel  dir  payload                                             handshake
//  in_ch    in   cmd, note_prescale, note_compare, note_duration     valid/ready
//  out_ch   out  tone_on, tone_prescale, tone_compare, queued_notes,  valid/ready
//                push_dropped
//
// Sequence: a push, a counting tick or an idle tick goes from accept to result;
//   a tick that starts a note adds the note store read between the two.
// One word at a time; a new word is taken once the previous result sits in the
//   output register, even if that result is still waiting.
// A stalled out_ch holds the sequencer in its result state until out_ready.
// Reset (rst_n low, synchronous) empties the queue, silences the active tone and
//   clears the countdown; the note store and the result register are not cleared.
module tone_note_queue_sequencer import tnq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input logic       clk,
  input logic       rst_n,
  tnq_in_if.sink    in_ch,
  tnq_out_if.source out_ch
);

`include "tone_note_queue_sequencer_macros.svh"

  ctl_cmd_t   cmd;
  dp_status_t status;

  // sequencing: decides per word whether to write, count down or fetch
  tnq_controller u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // queue, note store, countdown and result register
  tnq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .note_prescale(in_ch.note_prescale),
    .note_compare (in_ch.note_compare),
    .note_duration(in_ch.note_duration),
    .tone_on      (out_ch.tone_on),
    .tone_prescale(out_ch.tone_prescale),
    .tone_compare (out_ch.tone_compare),
    .queued_notes (out_ch.queued_notes),
    .push_dropped (out_ch.push_dropped)
  );

  // a store read is always followed by starting that note
  `TNQ_ASSERT_NEXT(a_fetch_then_load, cmd.rd_issue, cmd.load_note, "fetch not followed by load")
  // the note being started must still be in the queue
  `TNQ_ASSERT_NOW(a_load_not_empty, cmd.load_note, !status.empty, "load from empty queue")
  // one word in flight: no accept directly after an accept
  `TNQ_ASSERT_NEXT(a_one_in_flight, cmd.accept, !in_ch.ready, "ready straight after accept")

endmodule
